### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset (active-low synchronous reset).
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/uer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg
// Types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int STAMP_BITS_DEF = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd10;
    localparam logic [9:0]  SETTLE_TICKS_RST  = 10'd100;
    localparam logic [15:0] PHASE_LIMIT_RST   = 16'd30000;
    localparam logic [15:0] TOTAL_LIMIT_RST   = 16'd60000;

    // 58 = 2 * 29: halve, then divide by 29 with a reciprocal
    localparam int CM_DIV_ODD      = 29;
    localparam int CM_DIV_ODD_LOG2 = 5;

    localparam logic [15:0] TIMEOUT_CODE = 16'hFFFF;
    localparam logic [15:0] DIST_SAT     = 16'hFFFE;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TRIG,
        PH_SETTLE,
        PH_RISE,
        PH_FALL
    } t_phase;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_TRIGGER_TICKS,
        CFG_SETTLE_TICKS,
        CFG_PHASE_LIMIT,
        CFG_TOTAL_LIMIT
    } t_cfg_idx;

endpackage

### rtl/uer_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_in_if
// Tick request channel: start request and sampled echo level.
// ----------------------------------------------------------------------------
interface uer_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo;

    modport source (output valid, output start_req, output echo, input ready);
    modport sink   (input valid, input start_req, input echo, output ready);
endinterface

### rtl/uer_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_out_if
// Tick result channel: trigger level, completion and distance.
// ----------------------------------------------------------------------------
interface uer_out_if;
    logic        valid;
    logic        ready;
    logic        trig;
    logic        done_res;
    logic        timed_out;
    logic [15:0] distance_cm;

    modport source (output valid, output trig, output done_res, output timed_out,
                    output distance_cm, input ready);
    modport sink   (input valid, input trig, input done_res, input timed_out,
                    input distance_cm, output ready);
endinterface

### rtl/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Echo-pulse ranging sequencer: trigger, settle, edge stamps, width / 58 cm.
// ----------------------------------------------------------------------------
//  channel  | dir | request payload
//  ---------+-----+-------------------------------------------------
//  i_req    | in  | start_req, echo             (one per us tick)
//  o_res    | out | trig, done_res, timed_out, distance_cm
//  i_cfg_*  | in  | write enable, index, data   (no handshake)
//
//  One request per cycle while not stalled; each result is registered through
//  input reg -> sequencer reg -> divide-by-58 multiply -> output reg.
//  The whole pipe advances together; a waiting result with o_res.ready low
//  holds every stage.
//  Synchronous active-low reset: idle phase, empty pipe, default config.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ultrasonic_echo_ranger #(
    parameter int STAMP_BITS = uer_pkg::STAMP_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    uer_in_if.sink                              i_req,
    uer_out_if.source                           o_res,
    input  logic                                i_cfg_wr_en,
    input  logic [uer_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [uer_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int HALF_BITS = STAMP_BITS - 1;
    localparam int PROD_BITS = HALF_BITS + STAMP_BITS;
    localparam int Q_SHIFT   = HALF_BITS + uer_pkg::CM_DIV_ODD_LOG2;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << Q_SHIFT) / 64'(uer_pkg::CM_DIV_ODD)) + 64'd1;
    localparam logic [STAMP_BITS-1:0] RECIP = RECIP_FULL[STAMP_BITS-1:0];

    // configuration
    logic [7:0]  r_trigger_ticks;
    logic [9:0]  r_settle_ticks;
    logic [15:0] r_phase_limit;
    logic [15:0] r_total_limit;

    // stage A: input register
    logic r_a_vld;
    logic r_a_start;
    logic r_a_echo;

    // sequencer state
    uer_pkg::t_phase        r_phase, n_phase;
    logic [15:0]            r_phase_count, n_phase_count;
    logic [STAMP_BITS-1:0]  r_elapsed, n_elapsed;
    logic                   r_echo_prev;
    logic [STAMP_BITS-1:0]  r_rise_stamp, n_rise_stamp;

    // stage B
    logic                   r_b_vld;
    logic                   r_b_trig, n_b_trig;
    logic                   r_b_done, n_b_done;
    logic                   r_b_tmo, n_b_tmo;
    logic [STAMP_BITS-1:0]  r_b_width, n_b_width;

    // stage C: output register
    logic        r_c_vld;
    logic        r_c_trig;
    logic        r_c_done;
    logic        r_c_tmo;
    logic [15:0] r_c_dist, n_c_dist;

    logic                   adv;
    logic [STAMP_BITS-1:0]  elapsed_inc;
    logic [15:0]            cnt_inc;
    logic [15:0]            cnt_sat;
    logic                   start_end;
    logic                   trig_end;
    logic                   settle_end;
    logic                   over_total;
    logic                   lim_hit;
    logic                   rise_edge;
    logic                   fall_edge;
    logic [HALF_BITS-1:0]   half_width;
    logic [PROD_BITS-1:0]   prod;
    logic [31:0]            quot;

    assign adv         = !r_c_vld || o_res.ready;
    assign i_req.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks <= uer_pkg::TRIGGER_TICKS_RST;
            r_settle_ticks  <= uer_pkg::SETTLE_TICKS_RST;
            r_phase_limit   <= uer_pkg::PHASE_LIMIT_RST;
            r_total_limit   <= uer_pkg::TOTAL_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (uer_pkg::t_cfg_idx'(i_cfg_index))
                uer_pkg::CFG_TRIGGER_TICKS: r_trigger_ticks <= i_cfg_data[7:0];
                uer_pkg::CFG_SETTLE_TICKS:  r_settle_ticks  <= i_cfg_data[9:0];
                uer_pkg::CFG_PHASE_LIMIT:   r_phase_limit   <= i_cfg_data[15:0];
                uer_pkg::CFG_TOTAL_LIMIT:   r_total_limit   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_start <= i_req.start_req;
            r_a_echo  <= i_req.echo;
        end
    end

    // shared terms
    assign elapsed_inc = r_elapsed + {{(STAMP_BITS-1){1'b0}}, 1'b1};
    assign cnt_inc     = r_phase_count + 16'd1;
    assign cnt_sat     = (r_phase_count == uer_pkg::COUNT_MAX) ? r_phase_count : cnt_inc;
    assign start_end   = (16'd1 >= {8'd0, r_trigger_ticks});
    assign trig_end    = (cnt_inc >= {8'd0, r_trigger_ticks});
    assign settle_end  = (cnt_inc >= {6'd0, r_settle_ticks});
    assign over_total  = (32'(elapsed_inc) > 32'(r_total_limit));
    assign lim_hit     = over_total || (cnt_sat >= r_phase_limit);
    assign rise_edge   = r_a_echo && !r_echo_prev;
    assign fall_edge   = !r_a_echo && r_echo_prev;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            uer_pkg::PH_IDLE: begin
                if (r_a_start) begin
                    n_phase = start_end ? uer_pkg::PH_SETTLE : uer_pkg::PH_TRIG;
                end
            end
            uer_pkg::PH_TRIG: begin
                if (trig_end) begin
                    n_phase = uer_pkg::PH_SETTLE;
                end
            end
            uer_pkg::PH_SETTLE: begin
                if (settle_end) begin
                    n_phase = uer_pkg::PH_RISE;
                end
            end
            uer_pkg::PH_RISE: begin
                if (rise_edge) begin
                    n_phase = uer_pkg::PH_FALL;
                end else if (lim_hit) begin
                    n_phase = uer_pkg::PH_IDLE;
                end
            end
            uer_pkg::PH_FALL: begin
                if (fall_edge || lim_hit) begin
                    n_phase = uer_pkg::PH_IDLE;
                end
            end
            default: n_phase = uer_pkg::PH_IDLE;
        endcase
    end

    // counters, stamps and per-tick flags
    always_comb begin
        n_phase_count = r_phase_count;
        n_elapsed     = elapsed_inc;
        n_rise_stamp  = r_rise_stamp;
        n_b_trig      = 1'b0;
        n_b_done      = 1'b0;
        n_b_tmo       = 1'b0;
        n_b_width     = '0;
        unique case (r_phase)
            uer_pkg::PH_IDLE: begin
                n_elapsed = r_elapsed;
                if (r_a_start) begin
                    n_elapsed     = '0;
                    n_b_trig      = 1'b1;
                    n_phase_count = start_end ? 16'd0 : 16'd1;
                end
            end
            uer_pkg::PH_TRIG: begin
                n_b_trig      = 1'b1;
                n_phase_count = trig_end ? 16'd0 : cnt_inc;
            end
            uer_pkg::PH_SETTLE: begin
                n_phase_count = settle_end ? 16'd0 : cnt_inc;
            end
            uer_pkg::PH_RISE: begin
                if (rise_edge) begin
                    n_rise_stamp  = elapsed_inc;
                    n_phase_count = 16'd0;
                end else begin
                    n_phase_count = cnt_sat;
                    n_b_done      = lim_hit;
                    n_b_tmo       = lim_hit;
                end
            end
            uer_pkg::PH_FALL: begin
                if (fall_edge) begin
                    n_b_done  = 1'b1;
                    n_b_width = elapsed_inc - r_rise_stamp;
                end else begin
                    n_phase_count = cnt_sat;
                    n_b_done      = lim_hit;
                    n_b_tmo       = lim_hit;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= uer_pkg::PH_IDLE;
            r_phase_count <= '0;
            r_elapsed     <= '0;
            r_echo_prev   <= 1'b0;
            r_rise_stamp  <= '0;
            r_b_vld       <= 1'b0;
        end else if (adv) begin
            r_b_vld <= r_a_vld;
            if (r_a_vld) begin
                r_phase       <= n_phase;
                r_phase_count <= n_phase_count;
                r_elapsed     <= n_elapsed;
                r_echo_prev   <= r_a_echo;
                r_rise_stamp  <= n_rise_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_trig  <= n_b_trig;
            r_b_done  <= n_b_done;
            r_b_tmo   <= n_b_tmo;
            r_b_width <= n_b_width;
        end
    end

    // width / 58 = (width / 2) / 29 by reciprocal multiply
    assign half_width = r_b_width[STAMP_BITS-1:1];
    assign prod       = PROD_BITS'(half_width) * PROD_BITS'(RECIP);
    assign quot       = 32'(prod >> Q_SHIFT);

    always_comb begin
        if (r_b_tmo) begin
            n_c_dist = uer_pkg::TIMEOUT_CODE;
        end else if (!r_b_done) begin
            n_c_dist = '0;
        end else if (quot > 32'(uer_pkg::DIST_SAT)) begin
            n_c_dist = uer_pkg::DIST_SAT;
        end else begin
            n_c_dist = quot[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (adv) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_trig <= r_b_trig;
            r_c_done <= r_b_done;
            r_c_tmo  <= r_b_tmo;
            r_c_dist <= n_c_dist;
        end
    end

    assign o_res.valid       = r_c_vld;
    assign o_res.trig        = r_c_trig;
    assign o_res.done_res    = r_c_done;
    assign o_res.timed_out   = r_c_tmo;
    assign o_res.distance_cm = r_c_dist;

    `ASSERT_CLK_RST(a_tmo_code, i_clk, i_rst_n, (r_c_vld && r_c_tmo) |-> (r_c_done && r_c_dist == uer_pkg::TIMEOUT_CODE), "timeout result without done or timeout code")
    `ASSERT_CLK_RST(a_dist_idle, i_clk, i_rst_n, (r_c_vld && !r_c_done) |-> (r_c_dist == '0), "distance set on a tick without completion")
    `ASSERT_CLK_RST(a_done_to_idle, i_clk, i_rst_n, (adv && r_a_vld && n_b_done) |=> (r_phase == uer_pkg::PH_IDLE), "sequencer not idle after completion")
    `ASSERT_CLK(a_reset_empty, i_clk, !i_rst_n |=> (!r_a_vld && !r_b_vld && !r_c_vld), "pipe not empty after reset")

endmodule
